// ===== src/m2i_pkg.sv =====
// Shared types and constants of the 2x2 matrix inverse.
package m2i_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int ELEM_W        = 32;
  localparam int DET_W         = 64;
  localparam int THR_W         = 62;
  localparam int QW            = 33;
  localparam int LANES         = 4;
  localparam logic [THR_W-1:0] THR_RESET = 62'd281474977;

  typedef struct packed {
    logic [DET_W-1:0]  r;
    logic [QW-1:0]     q;
    logic              ovf;
    logic [ELEM_W-1:0] mag;
    logic              neg;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    logic                   sing;
    logic [DET_W-1:0]       dmag;
    logic                   dneg;
    lane_t [LANES-1:0]      lane;
  } chain_t;

endpackage

// ===== src/m2i_det.sv =====
// Determinant, its magnitude and the singular test, in three stages.
module m2i_det
  import m2i_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [ELEM_W-1:0] a00,
  input  logic signed [ELEM_W-1:0] a01,
  input  logic signed [ELEM_W-1:0] a10,
  input  logic signed [ELEM_W-1:0] a11,
  input  logic [THR_W-1:0]         det_threshold,
  output chain_t                   head
);

  logic                     v1, v2, v3;
  logic signed [DET_W-1:0]  p0, p1, det;
  logic [ELEM_W-1:0]        mag1 [LANES], mag2 [LANES];
  logic [LANES-1:0]         neg1, neg2;
  logic [DET_W-1:0]         dmag;
  logic                     dneg, sing;
  logic [ELEM_W-1:0]        mag3 [LANES];
  logic [LANES-1:0]         neg3;
  logic signed [ELEM_W-1:0] src [LANES];

  assign src[0] = a11;
  assign src[1] = a01;
  assign src[2] = a10;
  assign src[3] = a00;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    p0 <= DET_W'(a00) * DET_W'(a11);
    p1 <= DET_W'(a01) * DET_W'(a10);
    for (int i = 0; i < LANES; i++) begin
      mag1[i] <= src[i][ELEM_W-1] ? ELEM_W'(-src[i]) : ELEM_W'(src[i]);
      mag2[i] <= mag1[i];
      mag3[i] <= mag2[i];
    end
    // off-diagonal entries are negated in the adjugate
    neg1 <= {a00[ELEM_W-1], ~a10[ELEM_W-1], ~a01[ELEM_W-1], a11[ELEM_W-1]};
    neg2 <= neg1;
    neg3 <= neg2;
    det  <= p0 - p1;
    dneg <= det[DET_W-1];
    dmag <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    sing <= (det == '0) || ((det[DET_W-1] ? DET_W'(-det) : DET_W'(det))
            < {{(DET_W-THR_W){1'b0}}, det_threshold});
  end

  always_comb begin
    head.valid = v3;
    head.sing  = sing;
    head.dmag  = dmag;
    head.dneg  = dneg;
    for (int i = 0; i < LANES; i++) begin
      head.lane[i].r   = '0;
      head.lane[i].q   = '0;
      head.lane[i].ovf = 1'b0;
      head.lane[i].mag = mag3[i];
      head.lane[i].neg = neg3[i];
    end
  end

endmodule

// ===== src/m2i_div_cell.sv =====
// One restoring-division step for all four lanes.
module m2i_div_cell
  import m2i_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  chain_t din,
  output chain_t dout
);

  chain_t nxt;
  logic [DET_W:0] r2 [LANES];

  always_comb begin
    nxt = din;
    // drop the beat while in reset
    nxt.valid = din.valid && !rst;
    for (int i = 0; i < LANES; i++) begin
      r2[i] = {din.lane[i].r, din.lane[i].mag[ELEM_W-1]};
      nxt.lane[i].mag = {din.lane[i].mag[ELEM_W-2:0], 1'b0};
      nxt.lane[i].ovf = din.lane[i].ovf | din.lane[i].q[QW-1];
      if (r2[i] >= {1'b0, din.dmag}) begin
        nxt.lane[i].r = DET_W'(r2[i] - {1'b0, din.dmag});
        nxt.lane[i].q = {din.lane[i].q[QW-2:0], 1'b1};
      end else begin
        nxt.lane[i].r = r2[i][DET_W-1:0];
        nxt.lane[i].q = {din.lane[i].q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ===== src/m2i_round.sv =====
// Round to nearest, clip and sign the four quotients.
module m2i_round
  import m2i_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  chain_t                   tail,
  output logic                     done,
  output logic signed [ELEM_W-1:0] inv [LANES],
  output logic                     singular,
  output logic                     saturated
);

  logic              va, sing_a;
  logic [QW:0]       qr [LANES];
  logic [LANES-1:0]  ovf_a, neg_a;
  logic [ELEM_W:0]   lim [LANES];
  logic [LANES-1:0]  big;
  logic [ELEM_W-1:0] mval [LANES];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= tail.valid;
    sing_a <= tail.sing;
    for (int i = 0; i < LANES; i++) begin
      qr[i]    <= {1'b0, tail.lane[i].q} +
                  (QW+1)'({tail.lane[i].r, 1'b0} >= {1'b0, tail.dmag});
      ovf_a[i] <= tail.lane[i].ovf;
      neg_a[i] <= tail.lane[i].neg ^ tail.dneg;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lim[i]  = neg_a[i] ? {2'b01, {(ELEM_W-1){1'b0}}} : {2'b00, {(ELEM_W-1){1'b1}}};
      big[i]  = ovf_a[i] || (qr[i] > (QW+1)'(lim[i]));
      mval[i] = big[i] ? lim[i][ELEM_W-1:0] : qr[i][ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= va;
    singular  <= sing_a;
    saturated <= !sing_a && (|big);
    for (int i = 0; i < LANES; i++)
      inv[i] <= sing_a ? '0 : (neg_a[i] ? ELEM_W'(-mval[i]) : mval[i]);
  end

endmodule

// ===== src/matrix2x2_inverse_top.sv =====
// Top level of the pipelined 2x2 matrix inverse.
// Path from start to done: three determinant stages, one division cell per
// dividend bit, two rounding stages.
// Throughput: one beat per cycle; busy is never raised, the receiver cannot stall.
// Reset (synchronous, rst high) drops every beat in flight and sets the
// threshold to 1e-6 in Q16.48.
module matrix2x2_inverse_top
  import m2i_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] a00,
  input  logic signed [ELEM_W-1:0] a01,
  input  logic signed [ELEM_W-1:0] a10,
  input  logic signed [ELEM_W-1:0] a11,
  input  logic                     cfg_we,
  input  logic [THR_W-1:0]         cfg_data,
  output logic                     done,
  output logic signed [ELEM_W-1:0] inv00,
  output logic signed [ELEM_W-1:0] inv01,
  output logic signed [ELEM_W-1:0] inv10,
  output logic signed [ELEM_W-1:0] inv11,
  output logic                     singular,
  output logic                     saturated
);

  // one cell per dividend bit: 32 magnitude bits then 2*FRAC_BITS zero bits
  localparam int CELLS = ELEM_W + 2 * FRAC_BITS;

  logic [THR_W-1:0]         det_threshold;
  chain_t                   chain [CELLS+1];
  logic signed [ELEM_W-1:0] inv [LANES];

  // every beat enters the pipeline straight away
  assign busy = 1'b0;

  // hold the threshold; user writes it only while the pipeline is empty, unchecked
  always_ff @(posedge clk) begin
    if (rst)         det_threshold <= THR_RESET;
    else if (cfg_we) det_threshold <= cfg_data;
  end

  // determinant, magnitude and singular test
  m2i_det u_det (
    .clk, .rst,
    .in_valid (start),
    .a00, .a01, .a10, .a11,
    .det_threshold,
    .head     (chain[0])
  );

  // advance each quotient by one bit per cell
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    m2i_div_cell u_cell (
      .clk, .rst,
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // round, clip and drive the result beat
  m2i_round u_round (
    .clk, .rst,
    .tail (chain[CELLS]),
    .done,
    .inv,
    .singular,
    .saturated
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv10 = inv[2];
  assign inv11 = inv[3];

endmodule

// ===== src/m2i_checker.sv =====
// Port-level checks on the 2x2 matrix inverse, bound to the top level.
module m2i_checker
  import m2i_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic signed [ELEM_W-1:0] inv00,
  input logic signed [ELEM_W-1:0] inv01,
  input logic signed [ELEM_W-1:0] inv10,
  input logic signed [ELEM_W-1:0] inv11,
  input logic                     singular,
  input logic                     saturated
);

  localparam int LAT = ELEM_W + 2 * FRAC_BITS + 5;
  localparam logic signed [ELEM_W-1:0] MAXV = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] MINV = {1'b1, {(ELEM_W-1){1'b0}}};

  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_lat: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, LAT))
    else $error("result beat without a matching start");

  a_sing: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> inv00 == 0 && inv01 == 0 && inv10 == 0 && inv11 == 0
                         && !saturated)
    else $error("singular beat carries data");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> inv00 == MAXV || inv00 == MINV || inv01 == MAXV ||
                          inv01 == MINV || inv10 == MAXV || inv10 == MINV ||
                          inv11 == MAXV || inv11 == MINV)
    else $error("saturated beat without a clipped element");

endmodule

bind matrix2x2_inverse_top m2i_checker #(.FRAC_BITS(FRAC_BITS)) u_m2i_checker (
  .clk, .rst, .start, .busy, .done,
  .inv00, .inv01, .inv10, .inv11, .singular, .saturated
);

// ===== sim/matrix2x2_inverse_top_tb.sv =====
// Testbench for the 2x2 matrix inverse: directed and random matrices, scoreboard check.
module matrix2x2_inverse_top_tb;
  import m2i_pkg::*;

  localparam int FB       = FRAC_BITS_DEF;
  localparam int LATENCY  = 2 * FB + 37;
  localparam int WD_LIMIT = 4000;
  localparam logic signed [ELEM_W-1:0] ONE  = 32'sd1 <<< FB;
  localparam logic signed [ELEM_W-1:0] EMAX = 32'sh7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] EMIN = 32'sh8000_0000;

  // One expected inverse, as the block should present it.
  typedef struct {
    logic signed [ELEM_W-1:0] e00, e01, e10, e11;
    logic                     sing, sat;
  } inverse_t;

  class inverse_scoreboard;
    logic [THR_W-1:0] threshold;
    inverse_t         pending[$];
    int               errors;

    function new();
      threshold = THR_RESET;
      errors    = 0;
    endfunction

    // Exact quotient of one adjugate entry by the determinant, rounded half
    // away from zero, clipped to the element range.
    function automatic logic [ELEM_W-1:0] scaled_quotient(
        logic signed [ELEM_W:0] entry, logic [DET_W-1:0] dmag, logic dneg,
        ref logic sat);
      logic [127:0] num, q, r;
      logic [ELEM_W:0] mag;
      logic          rneg;
      logic [127:0]  lim;
      begin
        rneg = (entry < 0) != dneg;
        mag  = (entry < 0) ? -entry : entry;
        num  = 128'(mag) << (2 * FB);
        q    = num / 128'(dmag);
        r    = num % 128'(dmag);
        if (r >= 128'(dmag) - r) q = q + 1;
        lim = rneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
          q   = lim;
          sat = 1'b1;
        end
        return rneg ? ELEM_W'(-q) : ELEM_W'(q);
      end
    endfunction

    function automatic inverse_t predict_inverse(
        logic signed [ELEM_W-1:0] a00, a01, a10, a11);
      logic signed [DET_W+1:0] det;
      logic [DET_W-1:0]        dmag;
      logic                    dneg, sat;
      inverse_t                x;
      begin
        det  = (DET_W+2)'(a00) * (DET_W+2)'(a11) - (DET_W+2)'(a01) * (DET_W+2)'(a10);
        dneg = det < 0;
        dmag = DET_W'(dneg ? -det : det);
        sat  = 1'b0;
        x    = '{default: '0};
        if (dmag == 0 || dmag < 64'(threshold)) begin
          x.sing = 1'b1;
          return x;
        end
        x.e00  = scaled_quotient(a11, dmag, dneg, sat);
        x.e01  = scaled_quotient(-(ELEM_W+1)'(a01), dmag, dneg, sat);
        x.e10  = scaled_quotient(-(ELEM_W+1)'(a10), dmag, dneg, sat);
        x.e11  = scaled_quotient(a00, dmag, dneg, sat);
        x.sat  = sat;
        return x;
      end
    endfunction

    function void note_matrix(logic signed [ELEM_W-1:0] a00, a01, a10, a11);
      pending.push_back(predict_inverse(a00, a01, a10, a11));
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        $error("result beat with no matrix outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.e00 !== want.e00) begin
        $error("inv00: expected %0d, got %0d", want.e00, got.e00); errors++;
      end
      if (got.e01 !== want.e01) begin
        $error("inv01: expected %0d, got %0d", want.e01, got.e01); errors++;
      end
      if (got.e10 !== want.e10) begin
        $error("inv10: expected %0d, got %0d", want.e10, got.e10); errors++;
      end
      if (got.e11 !== want.e11) begin
        $error("inv11: expected %0d, got %0d", want.e11, got.e11); errors++;
      end
      if (got.sing !== want.sing) begin
        $error("singular: expected %0b, got %0b", want.sing, got.sing); errors++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, got.sat); errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [ELEM_W-1:0] a00 = '0, a01 = '0, a10 = '0, a11 = '0;
  logic                     cfg_we = 1'b0;
  logic [THR_W-1:0]         cfg_data = '0;
  logic                     done;
  logic signed [ELEM_W-1:0] inv00, inv01, inv10, inv11;
  logic                     singular, saturated;

  inverse_scoreboard sb = new();
  int                idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix2x2_inverse_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a00(a00), .a01(a01), .a10(a10), .a11(a11),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .inv00(inv00), .inv01(inv01), .inv10(inv10), .inv11(inv11),
    .singular(singular), .saturated(saturated)
  );

  // Monitor: note each accepted input beat, check each result beat, and
  // keep the watchdog running on cycles where neither side moves.
  always @(posedge clk) begin
    inverse_t got;
    if (!rst) begin
      if (start && !busy) sb.note_matrix(a00, a01, a10, a11);
      if (done) begin
        got = '{e00: inv00, e01: inv01, e10: inv10, e11: inv11,
                sing: singular, sat: saturated};
        sb.check_inverse(got);
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else if (idle_cycles + 1 >= WD_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one matrix and hold start until the block takes the beat.
  task automatic send_matrix(logic signed [ELEM_W-1:0] b00, b01, b10, b11);
    start <= 1'b1;
    a00 <= b00; a01 <= b01; a10 <= b10; a11 <= b11;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start, wait for every outstanding inverse, then let the pipe empty.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.threshold = value;
  endtask

  // Mix of element classes: full range, near unity, tiny, mid range and the extremes.
  function automatic logic signed [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 5)) inside
      [0:1]:   return $urandom;
      2:       return $signed($urandom_range(0, 2 * ONE)) - ONE;
      3:       return $signed($urandom_range(0, 511)) - 256;
      4:       return $urandom_range(0, 1) ? EMAX : EMIN;
      default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endcase
  endfunction

  // Random phase: bursts of random length with random gaps; a share of the
  // matrices is built rank-deficient or nearly so to exercise the threshold.
  task automatic random_phase(int count);
    logic signed [ELEM_W-1:0] p, q, r, s;
    int burst;
    while (count > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && count > 0; i++, count--) begin
        p = random_element(); q = random_element();
        r = random_element(); s = random_element();
        if ($urandom_range(0, 5) == 0) begin
          // second row a multiple of the first, nudged by a little
          r = p * 2 + $signed($urandom_range(0, 2)) - 1;
          s = q * 2;
        end
        send_matrix(p, q, r, s);
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
    end
  endtask

  task automatic directed_set();
    send_matrix(ONE, 0, 0, ONE);                  // identity
    send_matrix(0, 0, 0, 0);                      // zero determinant
    send_matrix(EMAX, EMAX, EMAX, EMAX);          // rank one at the top
    send_matrix(EMIN, 0, 0, EMIN);                // largest determinant
    send_matrix(EMIN, EMAX, EMAX, EMIN);          // extremes mixed
    send_matrix(EMAX, EMIN, EMIN, EMAX);
    send_matrix(0, ONE, ONE, 0);                  // negative determinant
    send_matrix(ONE, 0, 0, 17);                   // just above the reset threshold
    send_matrix(ONE, 0, 0, 16);                   // just below it
    send_matrix(1, 0, 0, 1);                      // tiny determinant, saturates
    send_matrix(-1, 0, 0, 1);
    send_matrix(2 * ONE, ONE, ONE, ONE);          // clean inverse
    send_matrix(3, 1, 1, 1);                      // tiny determinant
    send_matrix(-3, 1, 1, -1);
    send_matrix(ONE, 2, 3, 7 * ONE);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_set();
    random_phase(150);
    drain_results();

    write_threshold('0);
    directed_set();
    random_phase(150);
    drain_results();

    write_threshold({THR_W{1'b1}});
    directed_set();
    random_phase(100);
    drain_results();

    write_threshold(THR_W'({$urandom_range(0, 32'h3FFF_FFFF), $urandom}
                           >> $urandom_range(0, 40)));
    random_phase(150);
    drain_results();

    write_threshold(THR_RESET);
    directed_set();
    random_phase(150);
    drain_results();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
